// ----- hw/rtl/lpht_pkg.sv -----
// Shared types and constants for the linear probing hash table.
`default_nettype none

package lpht_pkg;

    // Table geometry
    localparam int TABLE_SIZE = 128;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 31;
    localparam int VAL_W      = 32;
    localparam int SLOT_W     = 7;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;

    // Last probe count of a bounded run
    localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(TABLE_SIZE - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);

    // Request kinds, coded as on the input mode field
    typedef enum logic [MODE_W-1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Per-slot state kept in the table memory
    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_USED  = 2'd1,
        ST_TOMB  = 2'd2
    } t_slot_st;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        RES_OK   = 2'd0,
        RES_MISS = 2'd1,
        RES_FULL = 2'd2
    } t_res;

    // Probe engine states
    typedef enum logic {
        S_IDLE  = 1'b0,
        S_CHECK = 1'b1
    } t_state;

    // One table word
    typedef struct packed {
        t_slot_st           status;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } t_entry;

    // One classified request in the queue
    typedef struct packed {
        t_op                op;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [IDX_W-1:0]   home;
    } t_req;

endpackage

`default_nettype wire

// ----- hw/rtl/lpht_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lpht_front.sv -----
// Front end: accepts requests, classifies them and queues them for the probe engine.
`default_nettype none

module lpht_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [lpht_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [lpht_pkg::KEY_W-1:0]    i_key,
    input  wire logic [lpht_pkg::VAL_W-1:0]    i_value,
    output logic                               o_q_vld,
    output lpht_pkg::t_req                     o_q_req,
    input  wire logic                          i_q_pop
);

    lpht_pkg::t_req r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    lpht_pkg::t_req req_in;
    logic           push;

    // Classify the incoming transaction
    always_comb begin
        req_in       = '0;
        req_in.key   = i_key;
        req_in.value = i_value;
        req_in.home  = lpht_pkg::IDX_W'(i_key % lpht_pkg::TABLE_SIZE);
        unique case (i_mode)
            lpht_pkg::OP_SEARCH: req_in.op = lpht_pkg::OP_SEARCH;
            lpht_pkg::OP_INSERT: req_in.op = lpht_pkg::OP_INSERT;
            lpht_pkg::OP_DELETE: req_in.op = lpht_pkg::OP_DELETE;
            default:             req_in.op = lpht_pkg::OP_NONE;
        endcase
    end

    assign o_s_axis_tready = (r_cnt != 2'd2);
    assign push            = i_s_axis_tvalid && o_s_axis_tready;

    // Two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= req_in;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    assign o_q_vld = (r_cnt != 2'd0);
    assign o_q_req = r_q[r_rp];

endmodule

`default_nettype wire

// ----- hw/rtl/lpht_back.sv -----
// Back end: probe engine over the slot table and the result register.
`default_nettype none

module lpht_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_vld,
    input  wire lpht_pkg::t_req                  i_q_req,
    output logic                                 o_q_pop,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic [lpht_pkg::STATUS_W-1:0]        o_status,
    output logic [lpht_pkg::VAL_W-1:0]           o_value,
    output logic [lpht_pkg::SLOT_W-1:0]          o_slot
);

    localparam int ENT_W = $bits(lpht_pkg::t_entry);

    lpht_pkg::t_state                   r_state, n_state;
    lpht_pkg::t_req                     r_req, n_req;
    logic [lpht_pkg::IDX_W-1:0]         r_idx, n_idx;
    logic [lpht_pkg::IDX_W-1:0]         r_cnt, n_cnt;
    logic [lpht_pkg::TABLE_SIZE-1:0]    r_valid;
    logic                               r_vld_q;
    logic                               r_out_vld;
    lpht_pkg::t_res                     r_out_status;
    logic [lpht_pkg::VAL_W-1:0]         r_out_value;
    logic [lpht_pkg::SLOT_W-1:0]        r_out_slot;

    logic                               rd_en;
    logic [lpht_pkg::IDX_W-1:0]         rd_addr;
    logic [ENT_W-1:0]                   rd_data;
    lpht_pkg::t_entry                   ent;
    logic                               wr_en;
    lpht_pkg::t_entry                   wr_ent;
    logic                               set_valid;
    logic                               out_free;
    logic                               out_load;
    lpht_pkg::t_res                     res_status;
    logic [lpht_pkg::VAL_W-1:0]         res_value;
    logic [lpht_pkg::SLOT_W-1:0]        res_slot;
    logic                               slot_empty;
    logic                               slot_used;
    logic                               last;
    logic [lpht_pkg::IDX_W-1:0]         idx_next;

    // Slot table: status, key and value in one word
    lpht_ram #(
        .WIDTH (ENT_W),
        .DEPTH (lpht_pkg::TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_idx),
        .i_wdata (wr_ent),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign ent        = lpht_pkg::t_entry'(rd_data);
    assign slot_empty = !r_vld_q || (ent.status == lpht_pkg::ST_EMPTY);
    assign slot_used  = r_vld_q && (ent.status == lpht_pkg::ST_USED);
    assign last       = (r_cnt == lpht_pkg::CNT_LAST);
    assign idx_next   = (r_idx == lpht_pkg::IDX_LAST) ? '0 : r_idx + 1'b1;
    assign out_free   = !r_out_vld || i_m_axis_tready;

    // Next state, probe control and result
    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        o_q_pop    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_idx;
        wr_en      = 1'b0;
        wr_ent     = ent;
        set_valid  = 1'b0;
        out_load   = 1'b0;
        res_status = lpht_pkg::RES_MISS;
        res_value  = '0;
        res_slot   = '0;
        unique case (r_state)
            lpht_pkg::S_IDLE: begin
                if (i_q_vld) begin
                    o_q_pop = 1'b1;
                    n_req   = i_q_req;
                    n_idx   = i_q_req.home;
                    n_cnt   = '0;
                    rd_en   = 1'b1;
                    rd_addr = i_q_req.home;
                    n_state = lpht_pkg::S_CHECK;
                end
            end
            lpht_pkg::S_CHECK: begin
                case (r_req.op)
                    lpht_pkg::OP_SEARCH, lpht_pkg::OP_DELETE: begin
                        if (slot_empty) begin
                            out_load = out_free;
                        end else if (slot_used && (ent.key == r_req.key)) begin
                            out_load   = out_free;
                            res_status = lpht_pkg::RES_OK;
                            res_value  = ent.value;
                            res_slot   = lpht_pkg::SLOT_W'(r_idx);
                            if (r_req.op == lpht_pkg::OP_DELETE) begin
                                wr_en         = out_free;
                                wr_ent.status = lpht_pkg::ST_TOMB;
                            end
                        end else if (last) begin
                            out_load = out_free;
                        end else begin
                            n_idx   = idx_next;
                            n_cnt   = r_cnt + 1'b1;
                            rd_en   = 1'b1;
                            rd_addr = idx_next;
                        end
                    end
                    lpht_pkg::OP_INSERT: begin
                        if (!slot_used) begin
                            out_load   = out_free;
                            res_status = lpht_pkg::RES_OK;
                            res_slot   = lpht_pkg::SLOT_W'(r_idx);
                            wr_en      = out_free;
                            set_valid  = out_free;
                            wr_ent     = '{status: lpht_pkg::ST_USED,
                                           key:    r_req.key,
                                           value:  r_req.value};
                        end else if (last) begin
                            out_load   = out_free;
                            res_status = lpht_pkg::RES_FULL;
                        end else begin
                            n_idx   = idx_next;
                            n_cnt   = r_cnt + 1'b1;
                            rd_en   = 1'b1;
                            rd_addr = idx_next;
                        end
                    end
                    default: begin
                        // unused mode: no probe, no change
                        out_load = out_free;
                    end
                endcase
                if (out_load) begin
                    n_state = lpht_pkg::S_IDLE;
                end
            end
            default: n_state = lpht_pkg::S_IDLE;
        endcase
    end

    // Engine state and per-slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpht_pkg::S_IDLE;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            if (set_valid) begin
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    // Probe datapath registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        if (rd_en) begin
            r_vld_q <= r_valid[rd_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= res_status;
            r_out_value  <= res_value;
            r_out_slot   <= res_slot;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_status        = r_out_status;
    assign o_value         = r_out_value;
    assign o_slot          = r_out_slot;

    // A request leaves the queue only when the engine is free
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == lpht_pkg::S_IDLE) && i_q_vld)
        else $error("queue popped while engine busy");

    // A failed operation reports zero value and slot
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (res_status != lpht_pkg::RES_OK)) |-> (res_value == '0) && (res_slot == '0))
        else $error("failed operation with nonzero value or slot");

    // The table is written only while a result is committed
    a_write_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> out_load && (r_state == lpht_pkg::S_CHECK))
        else $error("table write without result");

    // An inserted slot is marked valid afterwards
    a_insert_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        set_valid |=> r_valid[$past(r_idx)])
        else $error("inserted slot not marked valid");

endmodule

`default_nettype wire

// ----- hw/rtl/linear_probe_hash_table.sv -----
// Top level of the linear probing hash table: stream ports, front end and probe engine.
//
// Usage:
//   Requests enter on the slave stream. tuser carries the mode (0 search, 1 insert,
//   2 delete, 3 no-op); tdata carries key and value. Each request yields exactly one
//   result transaction on the master stream: tuser is the status (0 done or found,
//   1 not found, 2 full); tdata carries the returned value and the slot index.
//   A two-entry queue sits between the front end and the probe engine, so requests
//   are taken while the engine works or a result waits to be taken.
//   Timing: the engine probes one slot per cycle through the table memory's
//   registered read port. A request probes 1 to 128 slots; the home slot is read
//   as the request leaves the queue, and each further slot is read while the one
//   before it is checked.
//   Reset: all slots read as empty right after reset through per-slot valid bits
//   cleared at once; no clearing pass is needed.
//   Backpressure: while the result register is full and not taken, the engine holds
//   its final probe and the queue fills; tready drops when both entries are in use.
`default_nettype none

module linear_probe_hash_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // [30:0] key, [62:31] value, [63] zero
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] mode
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [31:0] value_out, [38:32] slot, [39] zero
    output logic [1:0]       o_m_axis_tuser    // [1:0] status
);

    logic                               q_vld;
    lpht_pkg::t_req                     q_req;
    logic                               q_pop;
    logic [lpht_pkg::STATUS_W-1:0]      status;
    logic [lpht_pkg::VAL_W-1:0]         value_out;
    logic [lpht_pkg::SLOT_W-1:0]        slot;

    // Request intake and queue
    lpht_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_mode          (i_s_axis_tuser),
        .i_key           (i_s_axis_tdata[30:0]),
        .i_value         (i_s_axis_tdata[62:31]),
        .o_q_vld         (q_vld),
        .o_q_req         (q_req),
        .i_q_pop         (q_pop)
    );

    // Probe engine and result register
    lpht_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_vld         (q_vld),
        .i_q_req         (q_req),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_status        (status),
        .o_value         (value_out),
        .o_slot          (slot)
    );

    // Result packing
    assign o_m_axis_tdata = {1'b0, slot, value_out};
    assign o_m_axis_tuser = status;

endmodule

`default_nettype wire
